// ----- design/handshake_connection_receiver_defines.svh -----
// assertion macros for the handshake connection receiver
`ifndef HANDSHAKE_CONNECTION_RECEIVER_DEFINES_SVH
`define HANDSHAKE_CONNECTION_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

`define HCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define HCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define HCR_ASSERT(lbl, prop, msg)

`define HCR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- design/hcr_pkg.sv -----
// shared types, constants and helpers of the handshake connection receiver
package hcr_pkg;

  localparam int SEQ_W  = 32;
  localparam int IDX_W  = 32;
  localparam int FLAG_W = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [FLAG_W-1:0] FLAG_SYN = 4'b0001;
  localparam logic [FLAG_W-1:0] FLAG_ACK = 4'b0010;
  localparam logic [FLAG_W-1:0] FLAG_FIN = 4'b0100;
  localparam logic [FLAG_W-1:0] FLAG_RST = 4'b1000;

  localparam logic REG_INITIAL_INDEX = 1'b0;
  localparam logic REG_START_ACTIVE  = 1'b1;

  typedef enum logic [1:0] {
    CS_CLOSED    = 2'd0,
    CS_SYN_SENT  = 2'd1,
    CS_SYN_RECV  = 2'd2,
    CS_CONNECTED = 2'd3
  } conn_state_e;

  typedef struct packed {
    logic             syn_only;
    logic             synack_only;
    logic             ack_only;
    logic             has_ack;
    logic             has_fin;
    logic             has_rst;
    logic [SEQ_W-1:0] peer_index;
    logic [SEQ_W-1:0] peer_ack_index;
  } hdr_class_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic              wr_init;
    logic              wr_start;
    logic [DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              reply_valid;
    logic [FLAG_W-1:0] reply_flags;
    logic [IDX_W-1:0]  reply_index;
    logic [IDX_W-1:0]  reply_ack_index;
    logic              reply_needs_ack;
    logic [1:0]        link_state;
  } reply_t;

  function automatic logic [SEQ_W-1:0] to_seq(input logic [IDX_W-1:0] v);
    return SEQ_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] from_seq(input logic [SEQ_W-1:0] v);
    return IDX_W'(v);
  endfunction

endpackage

// ----- design/hcr_hdr_if.sv -----
// received header channel
interface hcr_hdr_if import hcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] flags;
  logic [IDX_W-1:0]  peer_index;
  logic [IDX_W-1:0]  peer_ack_index;

  modport source (output valid, output flags, output peer_index, output peer_ack_index,
                  input ready);
  modport sink (input valid, input flags, input peer_index, input peer_ack_index,
                output ready);
endinterface

// ----- design/hcr_reply_if.sv -----
// reply header channel
interface hcr_reply_if import hcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reply_valid;
  logic [FLAG_W-1:0] reply_flags;
  logic [IDX_W-1:0]  reply_index;
  logic [IDX_W-1:0]  reply_ack_index;
  logic              reply_needs_ack;
  logic [1:0]        link_state;

  modport source (output valid, output reply_valid, output reply_flags, output reply_index,
                  output reply_ack_index, output reply_needs_ack, output link_state,
                  input ready);
  modport sink (input valid, input reply_valid, input reply_flags, input reply_index,
                input reply_ack_index, input reply_needs_ack, input link_state,
                output ready);
endinterface

// ----- design/handshake_connection_receiver.sv -----
// top level of the handshake connection receiver: register port, front, queue, back
//
// channel   direction  word
// hdr_i     in         flags, peer_index, peer_acknowledged index
// reply_o   out        reply_valid, reply_flags, reply_index, reply_ack_index,
//                      reply_needs_ack, link_state
// apb       in/out     initial_index at 0x0, start_active at 0x4
//
// one header per cycle while reply_o is ready; its reply passes the queue, then the reply register
// the rate is set by the state update in the back end
// every header gives exactly one reply word, also when no reply header is sent
// a stalled reply_o holds the reply register; the two-entry queue then fills and drops ready
// reset zeroes state, indices, config; not queue entries or reply register; no clearing pass
`include "handshake_connection_receiver_defines.svh"

module handshake_connection_receiver import hcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  hcr_hdr_if.sink           hdr_i,
  hcr_reply_if.source       reply_o
);

  logic [IDX_W-1:0] initial_index_q;
  logic             start_active_q;
  logic             wr_en;
  logic             reg_sel;
  cfg_wr_t          cfg;
  logic             push;
  hdr_class_t       push_data;
  logic             pop;
  hdr_class_t       pop_data;
  q_status_t        q_status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg.wr_init  = wr_en && (reg_sel == REG_INITIAL_INDEX);
    cfg.wr_start = wr_en && (reg_sel == REG_START_ACTIVE);
    cfg.data     = pwdata;
  end

  always_comb begin
    case (reg_sel)
      REG_INITIAL_INDEX: prdata = DATA_W'(initial_index_q);
      REG_START_ACTIVE:  prdata = DATA_W'(start_active_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_index_q <= '0;
      start_active_q  <= 1'b0;
    end else begin
      if (cfg.wr_init) begin
        initial_index_q <= IDX_W'(pwdata);
      end
      if (cfg.wr_start) begin
        start_active_q <= pwdata[0];
      end
    end
  end

  hcr_front u_front (
    .hdr_i       (hdr_i),
    .full_i      (q_status.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  hcr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .status_i   (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .reply_o    (reply_o)
  );

  `HCR_ASSERT(a_queue_status, $onehot0({q_status.full, q_status.empty}), "queue full and empty")
  `HCR_ASSERT(a_no_reply_zero, reply_o.valid && !reply_o.reply_valid |-> reply_o.reply_flags == '0 && reply_o.reply_index == '0 && reply_o.reply_ack_index == '0 && !reply_o.reply_needs_ack, "empty reply carries data")
  `HCR_ASSERT(a_needs_ack_synack, reply_o.valid && reply_o.reply_needs_ack |-> reply_o.reply_valid && reply_o.reply_flags == (FLAG_SYN | FLAG_ACK) && reply_o.link_state == 2'(CS_SYN_RECV), "acked reply not a syn-ack")
  `HCR_ASSERT(a_pop_needs_entry, pop |-> !q_status.empty, "pop from empty queue")

endmodule

// ----- design/hcr_front.sv -----
// front end: accepts received headers and classifies their flags
module hcr_front import hcr_pkg::*; (
  hcr_hdr_if.sink    hdr_i,
  input  logic       full_i,
  output logic       push_o,
  output hdr_class_t push_data_o
);

  assign hdr_i.ready = !full_i;
  assign push_o      = hdr_i.valid && !full_i;

  always_comb begin
    push_data_o.syn_only       = (hdr_i.flags == FLAG_SYN);
    push_data_o.synack_only    = (hdr_i.flags == (FLAG_SYN | FLAG_ACK));
    push_data_o.ack_only       = (hdr_i.flags == FLAG_ACK);
    push_data_o.has_ack        = |(hdr_i.flags & FLAG_ACK);
    push_data_o.has_fin        = |(hdr_i.flags & FLAG_FIN);
    push_data_o.has_rst        = |(hdr_i.flags & FLAG_RST);
    push_data_o.peer_index     = to_seq(hdr_i.peer_index);
    push_data_o.peer_ack_index = to_seq(hdr_i.peer_ack_index);
  end

endmodule

// ----- design/hcr_queue.sv -----
// short queue of classified headers between front and back
module hcr_queue import hcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hdr_class_t push_data_i,
  input  logic       pop_i,
  output hdr_class_t pop_data_o,
  output q_status_t  status_o
);

  hdr_class_t        entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o      = entry_q[rd_ptr_q];
  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == QCNT_W'(QDEPTH));

endmodule

// ----- design/hcr_back.sv -----
// back end: connection state machine, index registers and reply register
module hcr_back import hcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  q_status_t   status_i,
  input  hdr_class_t  pop_data_i,
  output logic        pop_o,
  hcr_reply_if.source reply_o
);

  conn_state_e       state_q, state_d;
  logic [SEQ_W-1:0]  local_q, local_d;
  logic [SEQ_W-1:0]  send_q, send_d;
  logic [SEQ_W-1:0]  ack_q, ack_d;
  logic              out_valid_q;
  reply_t            reply_q, reply_d;
  logic              ack_match;
  logic [SEQ_W-1:0]  peer_next;
  logic              rv;
  logic              rneed;
  logic [FLAG_W-1:0] rfl;

  assign pop_o = !status_i.empty && (!out_valid_q || reply_o.ready);

  always_comb begin
    state_d   = state_q;
    local_d   = local_q;
    send_d    = send_q;
    ack_d     = ack_q;
    rv        = 1'b0;
    rneed     = 1'b0;
    rfl       = '0;
    ack_match = ((local_q + SEQ_W'(1)) == pop_data_i.peer_ack_index);
    peer_next = pop_data_i.peer_index + SEQ_W'(1);
    if (pop_o) begin
      case (state_q)
        CS_CLOSED: begin
          if (pop_data_i.syn_only) begin
            state_d = CS_SYN_RECV;
            ack_d   = peer_next;
            rv      = 1'b1;
            rfl     = FLAG_SYN | FLAG_ACK;
            rneed   = 1'b1;
          end else if (pop_data_i.has_fin) begin
            ack_d = peer_next;
            rv    = 1'b1;
            rfl   = FLAG_ACK;
          end
        end
        CS_SYN_SENT: begin
          if (pop_data_i.synack_only && ack_match) begin
            state_d = CS_CONNECTED;
            local_d = pop_data_i.peer_ack_index;
            ack_d   = peer_next;
            rv      = 1'b1;
            rfl     = FLAG_ACK;
          end
        end
        CS_SYN_RECV: begin
          if (pop_data_i.ack_only && ack_match) begin
            state_d = CS_CONNECTED;
            local_d = pop_data_i.peer_ack_index;
            ack_d   = peer_next;
          end
        end
        CS_CONNECTED: begin
          if (pop_data_i.has_rst) begin
            state_d = CS_CLOSED;
          end else if (pop_data_i.has_fin) begin
            state_d = CS_CLOSED;
            ack_d   = peer_next;
            rv      = 1'b1;
            rfl     = FLAG_ACK;
          end else if (pop_data_i.has_ack && ack_match) begin
            local_d = pop_data_i.peer_ack_index;
          end
        end
        default: begin
          state_d = CS_CLOSED;
        end
      endcase
      if (rneed) begin
        send_d = send_q + SEQ_W'(1);
      end
    end
    if (cfg_i.wr_init) begin
      local_d = to_seq(IDX_W'(cfg_i.data));
      send_d  = to_seq(IDX_W'(cfg_i.data));
    end
    if (cfg_i.wr_start) begin
      state_d = cfg_i.data[0] ? CS_SYN_SENT : CS_CLOSED;
    end

    reply_d.reply_valid     = rv;
    reply_d.reply_flags     = rfl;
    reply_d.reply_index     = rv ? from_seq(send_q) : '0;
    reply_d.reply_ack_index = rv ? from_seq(ack_d) : '0;
    reply_d.reply_needs_ack = rneed;
    reply_d.link_state      = 2'(state_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_CLOSED;
      local_q     <= '0;
      send_q      <= '0;
      ack_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      local_q <= local_d;
      send_q  <= send_d;
      ack_q   <= ack_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (reply_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      reply_q <= reply_d;
    end
  end

  assign reply_o.valid           = out_valid_q;
  assign reply_o.reply_valid     = reply_q.reply_valid;
  assign reply_o.reply_flags     = reply_q.reply_flags;
  assign reply_o.reply_index     = reply_q.reply_index;
  assign reply_o.reply_ack_index = reply_q.reply_ack_index;
  assign reply_o.reply_needs_ack = reply_q.reply_needs_ack;
  assign reply_o.link_state      = reply_q.link_state;

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the handshake connection receiver
`timescale 1ns / 100ps

module tb;
  import hcr_pkg::*;

  localparam int TOTAL_HDRS = 550;
  localparam int CALM_TAIL  = 80;
  localparam logic [ADDR_W-1:0] ADDR_INITIAL_INDEX = ADDR_W'({REG_INITIAL_INDEX, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_START_ACTIVE  = ADDR_W'({REG_START_ACTIVE, 2'b00});

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [IDX_W-1:0]  peer_index;
    logic [IDX_W-1:0]  peer_ack_index;
  } hdr_word_t;

  typedef struct packed {
    conn_state_e      state;
    logic [SEQ_W-1:0] local_idx;
    logic [SEQ_W-1:0] send_idx;
    logic [SEQ_W-1:0] ack_idx;
  } link_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hcr_hdr_if   hdr ();
  hcr_reply_if reply ();

  handshake_connection_receiver u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr_i   (hdr),
    .reply_o (reply)
  );

  link_t     conn_model;
  link_t     conn_plan;
  hdr_word_t hdr_pending[$];
  reply_t    reply_expected[$];
  bit        idle_on;
  int        gap_cnt;
  int        stall_cnt;
  int        hdrs_queued;
  int        hdrs_accepted;
  int        replies_checked;
  int        reply_hdrs_seen;
  int        connects_seen;
  int        cfg_writes;
  int        phases;
  int        errors;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic reply_t link_step(inout link_t s, input hdr_word_t h);
    reply_t           r;
    logic [SEQ_W-1:0] pidx;
    logic [SEQ_W-1:0] pack;
    logic             ack_ok;
    r      = '0;
    pidx   = SEQ_W'(h.peer_index);
    pack   = SEQ_W'(h.peer_ack_index);
    ack_ok = (s.local_idx + 1'b1) == pack;
    case (s.state)
      CS_CLOSED: begin
        if (h.flags == FLAG_SYN) begin
          s.state           = CS_SYN_RECV;
          s.ack_idx         = pidx + 1'b1;
          r.reply_valid     = 1'b1;
          r.reply_flags     = FLAG_SYN | FLAG_ACK;
          r.reply_needs_ack = 1'b1;
        end else if ((h.flags & FLAG_FIN) != '0) begin
          s.ack_idx     = pidx + 1'b1;
          r.reply_valid = 1'b1;
          r.reply_flags = FLAG_ACK;
        end
      end
      CS_SYN_SENT: begin
        if (h.flags == (FLAG_SYN | FLAG_ACK) && ack_ok) begin
          s.state       = CS_CONNECTED;
          s.local_idx   = pack;
          s.ack_idx     = pidx + 1'b1;
          r.reply_valid = 1'b1;
          r.reply_flags = FLAG_ACK;
        end
      end
      CS_SYN_RECV: begin
        if (h.flags == FLAG_ACK && ack_ok) begin
          s.state     = CS_CONNECTED;
          s.local_idx = pack;
          s.ack_idx   = pidx + 1'b1;
        end
      end
      default: begin
        if ((h.flags & FLAG_RST) != '0) begin
          s.state = CS_CLOSED;
        end else if ((h.flags & FLAG_FIN) != '0) begin
          s.state       = CS_CLOSED;
          s.ack_idx     = pidx + 1'b1;
          r.reply_valid = 1'b1;
          r.reply_flags = FLAG_ACK;
        end else if ((h.flags & FLAG_ACK) != '0 && ack_ok) begin
          s.local_idx = pack;
        end
      end
    endcase
    if (r.reply_valid) begin
      r.reply_index     = IDX_W'(s.send_idx);
      r.reply_ack_index = IDX_W'(s.ack_idx);
      if (r.reply_needs_ack) begin
        s.send_idx = s.send_idx + 1'b1;
      end
    end
    r.link_state = s.state;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IDX_W'($urandom());
    endcase
  endfunction

  task automatic queue_hdr(input logic [FLAG_W-1:0] f, input logic [IDX_W-1:0] pi,
                           input logic [IDX_W-1:0] pa);
    hdr_word_t w;
    w.flags          = f;
    w.peer_index     = pi;
    w.peer_ack_index = pa;
    void'(link_step(conn_plan, w));
    hdr_pending.push_back(w);
    hdrs_queued++;
  endtask

  task automatic queue_random_hdr();
    logic [FLAG_W-1:0] f;
    logic [IDX_W-1:0]  pi;
    logic [IDX_W-1:0]  pa;
    logic [IDX_W-1:0]  next_idx;
    int                pick;
    next_idx = IDX_W'(conn_plan.local_idx + 1'b1);
    pi       = pick_index();
    pa       = IDX_W'($urandom());
    f        = FLAG_W'($urandom_range(0, 15));
    pick     = $urandom_range(0, 99);
    if (pick < 75) begin
      case (conn_plan.state)
        CS_CLOSED: begin
          if (pick < 60) f = FLAG_SYN;
          else f = f | FLAG_FIN;
        end
        CS_SYN_SENT: begin
          f  = FLAG_SYN | FLAG_ACK;
          pa = next_idx;
        end
        CS_SYN_RECV: begin
          f  = FLAG_ACK;
          pa = next_idx;
        end
        default: begin
          if (pick < 50) begin
            f  = FLAG_ACK | (f & FLAG_SYN);
            pa = next_idx;
          end else if (pick < 62) begin
            f = FLAG_FIN | (f & ~FLAG_RST);
          end else begin
            f = f | FLAG_RST;
          end
        end
      endcase
    end else if (pick < 88) begin
      pa = next_idx;
    end
    queue_hdr(f, pi, pa);
  endtask

  task automatic wait_quiet();
    while (hdr_pending.size() != 0 || hdr.valid || reply_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_INITIAL_INDEX) begin
      conn_model.local_idx = SEQ_W'(data);
      conn_model.send_idx  = SEQ_W'(data);
    end else begin
      conn_model.state = data[0] ? CS_SYN_SENT : CS_CLOSED;
    end
    conn_plan = conn_model;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] exp_v,
                             input logic [IDX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // header driver
  always @(posedge clk_i) begin
    hdr_word_t w;
    link_t     prev;
    if (rst_ni && hdr.valid && hdr.ready) begin
      w.flags          = hdr.flags;
      w.peer_index     = hdr.peer_index;
      w.peer_ack_index = hdr.peer_ack_index;
      prev = conn_model;
      reply_expected.push_back(link_step(conn_model, w));
      if (conn_model.state == CS_CONNECTED && prev.state != CS_CONNECTED) connects_seen++;
      hdrs_accepted++;
    end
    if (!hdr.valid || hdr.ready) begin
      if (gap_cnt > 0) begin
        hdr.valid <= 1'b0;
        gap_cnt--;
      end else if (rst_ni && hdr_pending.size() != 0) begin
        w = hdr_pending.pop_front();
        hdr.valid          <= 1'b1;
        hdr.flags          <= w.flags;
        hdr.peer_index     <= w.peer_index;
        hdr.peer_ack_index <= w.peer_ack_index;
        if (idle_on && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 11);
      end else begin
        hdr.valid <= 1'b0;
      end
    end
  end

  // reply monitor
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && reply.valid && reply.ready) begin
      if (reply_expected.size() == 0) begin
        $error("reply word with no header pending");
        errors++;
      end else begin
        want = reply_expected.pop_front();
        check_field("reply_valid", IDX_W'(want.reply_valid), IDX_W'(reply.reply_valid));
        check_field("reply_flags", IDX_W'(want.reply_flags), IDX_W'(reply.reply_flags));
        check_field("reply_index", want.reply_index, reply.reply_index);
        check_field("reply_ack_index", want.reply_ack_index, reply.reply_ack_index);
        check_field("reply_needs_ack", IDX_W'(want.reply_needs_ack),
                    IDX_W'(reply.reply_needs_ack));
        check_field("link_state", IDX_W'(want.link_state), IDX_W'(reply.link_state));
        if (want.reply_valid) reply_hdrs_seen++;
        replies_checked++;
      end
    end
    if (stall_cnt > 0) begin
      reply.ready <= 1'b0;
      stall_cnt--;
    end else begin
      reply.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 6) == 0) stall_cnt = $urandom_range(1, 11);
    end
  end

  initial begin
    #5_000_000;
    $display("[handshake_connection_receiver] ERROR");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] init_v;
    int                n;
    int                waited;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    hdr.valid          = 1'b0;
    hdr.flags          = '0;
    hdr.peer_index     = '0;
    hdr.peer_ack_index = '0;
    reply.ready        = 1'b0;
    conn_model         = '0;
    conn_model.state   = CS_CLOSED;
    conn_plan          = conn_model;
    idle_on            = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, closed side opening and teardown
    queue_hdr('0, '0, '0);
    queue_hdr(FLAG_FIN, '1, '0);
    queue_hdr(FLAG_SYN | FLAG_ACK, 32'h1234_5678, 32'h1);
    queue_hdr(FLAG_SYN, '1, '1);
    queue_hdr(FLAG_ACK, 32'h10, 32'h2);
    queue_hdr(FLAG_SYN | FLAG_ACK, 32'h10, 32'h1);
    queue_hdr(FLAG_ACK, 32'h10, 32'h1);
    queue_hdr(FLAG_ACK | FLAG_SYN, 32'h11, 32'h2);
    queue_hdr(FLAG_ACK, 32'h12, 32'h7);
    queue_hdr('1, 32'h13, 32'h3);
    queue_hdr(FLAG_SYN, 32'h8000_0000, '0);
    queue_hdr(FLAG_ACK, 32'h8000_0001, 32'h1);
    queue_hdr(FLAG_FIN | FLAG_ACK, '1, '0);
    wait_quiet();

    // active open with wrapping local index
    cfg_write(ADDR_INITIAL_INDEX, '1);
    cfg_write(ADDR_START_ACTIVE, 32'h1);
    queue_hdr(FLAG_SYN | FLAG_ACK, 32'h55, 32'h1);
    queue_hdr(FLAG_SYN, 32'h55, '0);
    queue_hdr(FLAG_SYN | FLAG_ACK | FLAG_FIN, 32'h55, '0);
    queue_hdr(FLAG_SYN | FLAG_ACK, '1, '0);
    queue_hdr(FLAG_ACK, 32'h66, 32'h1);
    queue_hdr(FLAG_RST | FLAG_FIN, 32'h77, '0);
    queue_hdr(FLAG_FIN | FLAG_SYN, 32'h78, '0);
    queue_hdr(FLAG_SYN, 32'h79, '0);
    wait_quiet();

    while (hdrs_queued < TOTAL_HDRS) begin
      case (phases % 4)
        0: init_v = '0;
        1: init_v = '1;
        2: init_v = 32'hFFFF_FFFE;
        default: init_v = pick_index();
      endcase
      if ($urandom_range(0, 3) != 0) cfg_write(ADDR_INITIAL_INDEX, init_v);
      cfg_write(ADDR_START_ACTIVE, DATA_W'($urandom_range(0, 1)));
      idle_on = (hdrs_queued < TOTAL_HDRS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 50);
      repeat (n) queue_random_hdr();
      phases++;
      wait_quiet();
    end

    waited = 0;
    while (reply_expected.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (reply_expected.size() != 0) begin
      $error("%0d reply words never arrived", reply_expected.size());
      errors++;
    end
    $display("ran %0d headers in %0d random phases with %0d register writes",
             hdrs_accepted, phases, cfg_writes);
    $display("checked %0d reply words, %0d carried a header, %0d connections set up",
             replies_checked, reply_hdrs_seen, connects_seen);
    if (errors == 0) begin
      $display("[handshake_connection_receiver] OK");
    end else begin
      $display("[handshake_connection_receiver] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/hcr_pkg.sv
design/hcr_hdr_if.sv
design/hcr_reply_if.sv
design/hcr_front.sv
design/hcr_queue.sv
design/hcr_back.sv
design/handshake_connection_receiver.sv
tb/sv/tb.sv
